[src/ptne_pkg.sv]
// ----------------------------------------------------------------------------
// ptne_pkg: shared types and constants of the nearest-point edit table
// Request and status codes, sequencer states, beat structures and the
// control bundle between the sequencer and the distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ptne_pkg;

  // Coordinate width is fixed by the width of the point fields.
  localparam int COORD_BITS = 20;
  localparam int REQ_W      = 3;
  localparam int VSEL_W     = 3;
  localparam int SLOT_W     = 6;
  localparam int LCOUNT_W   = 7;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR          = 3'd0,
    REQ_APPEND         = 3'd1,
    REQ_REMOVE_LAST    = 3'd2,
    REQ_REMOVE_AT      = 3'd3,
    REQ_FIND_NEAREST   = 3'd4,
    REQ_REMOVE_NEAREST = 3'd5,
    REQ_MOVE_NEAREST   = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [VSEL_W-1:0] view_sel;
    coord_t            point_x;
    coord_t            point_y;
    logic [SLOT_W-1:0] slot_sel;
  } in_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_found;
    logic [LCOUNT_W-1:0] list_count;
    status_e             status;
  } out_beat_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic clear;  // forget the best candidate before a new search
    logic valid;  // a stored point is presented this cycle
  } dist_ctl_t;

endpackage

`default_nettype wire

[src/point_table_nearest_edit.sv]
// ----------------------------------------------------------------------------
// point_table_nearest_edit: per-view point lists with nearest-point edits
// Sequencer, per-view counts and the glue around the point memory and the
// shared distance unit.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low, and busy then
// stays high until the single result beat has been shown on out_beat for one
// cycle with out_strobe high; the receiver cannot hold a result off, so it
// must sample every strobed beat. Clear, append, remove last, an unused code
// and a bad view go straight from decode to the result. Find nearest and move
// nearest scan the list, reading one stored point a cycle from the memory port
// into the three-stage distance unit. Remove at index i moves each later point
// down, reading one point and writing it one place down each cycle; removing
// the last point moves nothing. Remove nearest runs the scan and then that
// shift from the nearest slot. The point memory needs no clearing after reset:
// only slots below a view's count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module point_table_nearest_edit #(
  parameter int VIEW_COUNT = 8,
  parameter int MAX_POINTS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  ptne_pkg::in_beat_t in_beat,
  output logic               out_strobe,
  output ptne_pkg::out_beat_t out_beat
);
  import ptne_pkg::*;

  localparam int VIEW_W = (VIEW_COUNT > 1) ? $clog2(VIEW_COUNT) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int DEPTH  = VIEW_COUNT * MAX_POINTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  // Sequencer and request registers.
  state_e             state_r, state_nxt;
  in_beat_t           req_r, req_nxt;
  logic               view_ok_r, view_ok_nxt;
  logic [VIEW_W-1:0]  view_r, view_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;

  // Read pointer shared by the scan and the shift, and the tag of the point
  // whose read data arrives this cycle.
  logic [CNT_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic               smp_v_r, smp_v_nxt;
  logic [IDX_W-1:0]   smp_idx_r, smp_idx_nxt;

  logic [IDX_W-1:0]   res_slot_r, res_slot_nxt;
  status_e            res_status_r, res_status_nxt;

  // Points per view; a reset clears them all at once.
  logic [CNT_W-1:0]   counts_r [VIEW_COUNT];
  logic               cnt_we;
  logic [CNT_W-1:0]   cnt_wval;

  // Memory and distance unit hookup.
  logic               mem_wr_en, mem_rd_en;
  logic [ADDR_W-1:0]  mem_wr_addr, mem_rd_addr;
  point_t             mem_wr_data, mem_rd_data;
  point_t             qry;
  dist_ctl_t          dist_ctl;
  logic               dist_drained;
  logic [IDX_W-1:0]   best_idx;

  // Request decode helpers.
  logic [VIEW_W-1:0]  view_in;
  logic               view_ok_in;
  logic               is_full, is_empty, sel_bad;
  logic               rd_more, scan_done, shift_done;
  logic [CNT_W-1:0]   n_dec;

  ptne_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ptne_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dist_ctl),
    .smp_idx  (smp_idx_r),
    .smp      (mem_rd_data),
    .qry      (qry),
    .drained  (dist_drained),
    .best_idx (best_idx)
  );

  assign view_in    = VIEW_W'(in_beat.view_sel);
  assign view_ok_in = 32'(in_beat.view_sel) < VIEW_COUNT;
  assign qry        = '{x: req_r.point_x, y: req_r.point_y};

  assign is_full    = (n_r >= MAX_CNT);
  assign is_empty   = (n_r == '0);
  assign sel_bad    = (32'(req_r.slot_sel) >= 32'(n_r));
  assign n_dec      = n_r - CNT_W'(1);

  // The pointer always starts at or below the count, so it ends exactly on it.
  assign rd_more    = (rd_ptr_r != n_r);
  assign shift_done = !rd_more && !smp_v_r;
  assign scan_done  = shift_done && dist_drained;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_RESULT;
        if (view_ok_r) begin
          case (req_r.req_type)
            REQ_REMOVE_AT: begin
              if (!sel_bad) begin
                state_nxt = S_SHIFT;
              end
            end
            REQ_FIND_NEAREST, REQ_REMOVE_NEAREST, REQ_MOVE_NEAREST: begin
              if (!is_empty) begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = (req_r.req_type == REQ_REMOVE_NEAREST) ? S_SHIFT : S_RESULT;
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: handshake, result beat, memory and distance
  // unit control.
  always_comb begin
    busy                = (state_r != S_IDLE);
    out_strobe          = (state_r == S_RESULT);
    out_beat.slot_found = SLOT_W'(res_slot_r);
    out_beat.list_count = view_ok_r ? LCOUNT_W'(counts_r[view_r]) : '0;
    out_beat.status     = res_status_r;

    mem_rd_en   = ((state_r == S_SCAN) || (state_r == S_SHIFT)) && rd_more;
    mem_rd_addr = base_r + ADDR_W'(rd_ptr_r[IDX_W-1:0]);

    mem_wr_en   = 1'b0;
    mem_wr_addr = base_r + ADDR_W'(n_r[IDX_W-1:0]);
    mem_wr_data = qry;
    case (state_r)
      S_DECODE: begin
        mem_wr_en = view_ok_r && (req_r.req_type == REQ_APPEND) && !is_full;
      end
      S_SCAN: begin
        mem_wr_en   = scan_done && (req_r.req_type == REQ_MOVE_NEAREST);
        mem_wr_addr = base_r + ADDR_W'(best_idx);
      end
      S_SHIFT: begin
        // The point read last cycle moves one slot down.
        mem_wr_en   = smp_v_r;
        mem_wr_addr = base_r + ADDR_W'(smp_idx_r - IDX_W'(1));
        mem_wr_data = mem_rd_data;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase

    dist_ctl.clear = (state_r == S_DECODE);
    dist_ctl.valid = (state_r == S_SCAN) && smp_v_r;
  end

  // Datapath next values.
  always_comb begin
    req_nxt        = req_r;
    view_ok_nxt    = view_ok_r;
    view_nxt       = view_r;
    base_nxt       = base_r;
    n_nxt          = n_r;
    rd_ptr_nxt     = rd_ptr_r;
    smp_v_nxt      = 1'b0;
    smp_idx_nxt    = smp_idx_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    cnt_we         = 1'b0;
    cnt_wval       = n_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt     = in_beat;
          view_ok_nxt = view_ok_in;
          view_nxt    = view_in;
          base_nxt    = ADDR_W'(32'(view_in) * MAX_POINTS);
          n_nxt       = view_ok_in ? counts_r[view_in] : '0;
        end
      end
      S_DECODE: begin
        res_slot_nxt   = '0;
        res_status_nxt = ST_OK;
        if (!view_ok_r) begin
          res_status_nxt = ST_BAD_INDEX;
        end else begin
          case (req_r.req_type)
            REQ_CLEAR: begin
              cnt_we   = 1'b1;
              cnt_wval = '0;
            end
            REQ_APPEND: begin
              if (is_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                cnt_we       = 1'b1;
                cnt_wval     = n_r + CNT_W'(1);
                res_slot_nxt = n_r[IDX_W-1:0];
              end
            end
            REQ_REMOVE_LAST: begin
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                cnt_we       = 1'b1;
                cnt_wval     = n_dec;
                res_slot_nxt = n_dec[IDX_W-1:0];
              end
            end
            REQ_REMOVE_AT: begin
              if (sel_bad) begin
                res_status_nxt = ST_BAD_INDEX;
              end else begin
                res_slot_nxt = IDX_W'(req_r.slot_sel);
                rd_ptr_nxt   = CNT_W'(req_r.slot_sel) + CNT_W'(1);
              end
            end
            REQ_FIND_NEAREST, REQ_REMOVE_NEAREST, REQ_MOVE_NEAREST: begin
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_ptr_nxt = '0;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        smp_v_nxt   = rd_more;
        smp_idx_nxt = rd_ptr_r[IDX_W-1:0];
        if (rd_more) begin
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        end
        if (scan_done) begin
          res_slot_nxt = best_idx;
          rd_ptr_nxt   = CNT_W'(best_idx) + CNT_W'(1);
        end
      end
      S_SHIFT: begin
        smp_v_nxt   = rd_more;
        smp_idx_nxt = rd_ptr_r[IDX_W-1:0];
        if (rd_more) begin
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        end
        if (shift_done) begin
          cnt_we   = 1'b1;
          cnt_wval = n_dec;
        end
      end
      default: begin
        smp_v_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      smp_v_r <= 1'b0;
      for (int v = 0; v < VIEW_COUNT; v++) begin
        counts_r[v] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      smp_v_r <= smp_v_nxt;
      if (cnt_we) begin
        counts_r[view_r] <= cnt_wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    view_ok_r    <= view_ok_nxt;
    view_r       <= view_nxt;
    base_r       <= base_nxt;
    n_r          <= n_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    smp_idx_r    <= smp_idx_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
  end

endmodule

`default_nettype wire

[src/ptne_store.sv]
// ----------------------------------------------------------------------------
// ptne_store: point memory
// One write port and one read port with registered read data; each word
// holds the x and y coordinate of one stored point.
// ----------------------------------------------------------------------------
`default_nettype none

module ptne_store #(
  parameter int DEPTH = 512,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  ptne_pkg::point_t       wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output ptne_pkg::point_t       rd_data
);
  import ptne_pkg::*;

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/ptne_dist.sv]
// ----------------------------------------------------------------------------
// ptne_dist: pipelined squared-distance and running-minimum unit
// Takes one stored point a cycle, forms the exact squared distance to the
// query point over three stages and keeps the first index of least distance.
// ----------------------------------------------------------------------------
`default_nettype none

module ptne_dist #(
  parameter int IDX_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  ptne_pkg::dist_ctl_t   ctl,
  input  wire logic [IDX_W-1:0] smp_idx,
  input  ptne_pkg::point_t      smp,
  input  ptne_pkg::point_t      qry,
  output logic                  drained,
  output logic [IDX_W-1:0]      best_idx
);
  import ptne_pkg::*;

  localparam int MAG_W  = COORD_BITS;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = SQ_W + 1;

  logic signed [DIFF_W-1:0] dx, dy;
  logic [MAG_W-1:0]         adx_nxt, ady_nxt;
  logic [MAG_W-1:0]         adx_r, ady_r;
  logic [IDX_W-1:0]         a_idx_r, b_idx_r;
  logic                     a_v_r, b_v_r;
  logic [SQ_W-1:0]          sqx_nxt, sqy_nxt;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic [SUM_W-1:0]         sum_nxt;
  logic [SUM_W-1:0]         best_d_r;
  logic [IDX_W-1:0]         best_idx_r;
  logic                     have_r;
  logic                     take;

  // Stage A: magnitudes of the coordinate differences. The difference of two
  // coordinates never reaches the most negative value, so the magnitude fits.
  always_comb begin
    dx      = DIFF_W'(smp.x) - DIFF_W'(qry.x);
    dy      = DIFF_W'(smp.y) - DIFF_W'(qry.y);
    adx_nxt = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    ady_nxt = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
  end

  // Stage B: squares.
  always_comb begin
    sqx_nxt = adx_r * adx_r;
    sqy_nxt = ady_r * ady_r;
  end

  // Stage C: sum and compare; a strict compare keeps the lowest index on a tie.
  always_comb begin
    sum_nxt = SUM_W'(sqx_r) + SUM_W'(sqy_r);
    take    = b_v_r && (!have_r || (sum_nxt < best_d_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      have_r <= 1'b0;
    end else begin
      a_v_r <= ctl.valid;
      b_v_r <= a_v_r;
      if (ctl.clear) begin
        have_r <= 1'b0;
      end else if (take) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    adx_r   <= adx_nxt;
    ady_r   <= ady_nxt;
    a_idx_r <= smp_idx;
    sqx_r   <= sqx_nxt;
    sqy_r   <= sqy_nxt;
    b_idx_r <= a_idx_r;
    if (take) begin
      best_d_r   <= sum_nxt;
      best_idx_r <= b_idx_r;
    end
  end

  assign drained  = !a_v_r && !b_v_r;
  assign best_idx = best_idx_r;

endmodule

`default_nettype wire

[src/ptne_checker.sv]
// ----------------------------------------------------------------------------
// ptne_checker: port-level checks of the nearest-point edit table
// Watches the request and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptne_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           out_strobe,
  input ptne_pkg::out_beat_t out_beat
);
  import ptne_pkg::*;

  // An accepted request always sets busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted request beat");

  // A result beat is only shown while the request is still in hand.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result beat shown while the block was idle");

  // One result per request: after the beat the block is ready again.
  a_strobe_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> (!busy && !out_strobe))
    else $error("block stayed busy or repeated the result beat");

  // A request that fails reports slot zero.
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_beat.status != ST_OK)) |-> (out_beat.slot_found == '0))
    else $error("failed request reported a non-zero slot");

endmodule

bind point_table_nearest_edit ptne_checker u_ptne_checker (.*);

`default_nettype wire
